// ----- src/spr_pkg.sv -----
// ----------------------------------------------------------------------------
// spr_pkg
// Types, codes and character constants for the sensor poll response parser.
// ----------------------------------------------------------------------------
`default_nettype none

package spr_pkg;

  // input commands
  localparam logic [1:0] CMD_POLL = 2'd0;
  localparam logic [1:0] CMD_BYTE = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // result kinds
  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // report status
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_OVERFLOW   = 2'd1;
  localparam logic [1:0] ST_TIMEOUT    = 2'd2;
  localparam logic [1:0] ST_INCOMPLETE = 2'd3;

  // register indexes
  localparam logic REG_DEV_ADDR = 1'b0;
  localparam logic REG_TIMEOUT  = 1'b1;

  // token phases
  localparam logic [1:0] PH_SPACE  = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  localparam logic [2:0] NUM_FIELDS = 3'd6;
  localparam logic [2:0] MARK_LEN   = 3'd6;

  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef logic [15:0] val_t;
  typedef val_t [5:0] vals_t;

  typedef struct packed {
    logic [2:0]  count;
    logic        in_token;
    logic [1:0]  phase;
    logic        negative;
    logic [15:0] acc;
  } prs_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  // expected character at each place of the device prefix
  function automatic logic [7:0] mark_char(logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h33;
      3'd1:    c = 8'h32;
      3'd2:    c = 8'h34;
      3'd3:    c = 8'h30;
      3'd4:    c = 8'h30;
      3'd5:    c = 8'h21;
      default: c = 8'hFF;
    endcase
    return c;
  endfunction

  function automatic val_t prs_value(prs_t p);
    return p.negative ? 16'(17'd0 - {1'b0, p.acc}) : p.acc;
  endfunction

  function automatic prs_t prs_close(prs_t p);
    prs_t q;
    q = p;
    if (p.in_token) begin
      if (p.count < NUM_FIELDS) q.count = p.count + 3'd1;
      q.in_token = 1'b0;
    end
    return q;
  endfunction

  function automatic prs_t prs_feed(prs_t p, logic [7:0] c);
    prs_t q;
    q = p;
    if (c == CH_COMMA) begin
      q = prs_close(p);
    end else begin
      if (!p.in_token) begin
        q.in_token = 1'b1;
        q.phase    = PH_SPACE;
        q.negative = 1'b0;
        q.acc      = '0;
      end
      if (q.phase == PH_SPACE) begin
        if (is_blank(c)) begin
          q.phase = PH_SPACE;
        end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
          q.negative = (c == CH_MINUS);
          q.phase    = PH_DIGITS;
        end else if (is_digit(c)) begin
          q.acc   = {12'd0, c[3:0]};
          q.phase = PH_DIGITS;
        end else begin
          q.phase = PH_DONE;
        end
      end else if (q.phase == PH_DIGITS) begin
        if (is_digit(c)) q.acc = (q.acc << 3) + (q.acc << 1) + {12'd0, c[3:0]};
        else q.phase = PH_DONE;
      end
    end
    return q;
  endfunction

endpackage

`default_nettype wire

// ----- src/sensor_poll_response_parser_unit.sv -----
// ----------------------------------------------------------------------------
// sensor_poll_response_parser_unit
// Sends poll commands to a serial sensor box and parses its comma-separated
// response line into six 16-bit values, with overflow and timeout reports.
// ----------------------------------------------------------------------------
//  channel | ports                        | payload
//  in      | in_tvalid/in_tready          | tuser: command, tdata: rx_byte
//  out     | out_tvalid/out_tready/tlast  | tuser: kind, tdata: tx_byte..input_four
//  cfg     | cfg_wr_en/cfg_index/cfg_wdata| device_address, timeout_ticks
//
//  Each item is held in the input register; its result loads into the result
//  register as the item leaves. Items that give no result pass at one per cycle.
//  A poll gives three transmit items: M, the device address and !. An item that
//  gives a result waits in the input register until the last item of the run
//  before it is taken; a stalled result holds in the result register. Reset
//  (rst_n low, synchronous) clears valid flags, parse state and stored values.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_poll_response_parser_unit #(
  parameter int LINE_CAPACITY = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]   in_tuser,   // [1:0] command
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [111:0]      out_tdata,  // tx_byte, status, data_valid, wind_speed,
                                        // wind_direction, input_one..input_four, pad
  output logic              out_tuser,  // kind
  output logic              out_tlast,
  input  wire logic         cfg_wr_en,
  input  wire logic         cfg_index,
  input  wire logic [31:0]  cfg_wdata
);
  import spr_pkg::*;

  localparam logic [7:0] OVF_LEN = 8'(LINE_CAPACITY - 1);

  // configuration
  logic [7:0]  dev_addr_r;
  logic [31:0] timeout_r;

  // input register
  logic        in_valid_r;
  logic [1:0]  in_cmd_r;
  logic [7:0]  in_byte_r;

  // parse state
  logic        waiting_r, waiting_nxt;
  logic        line_started_r, line_started_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;
  logic [7:0]  line_len_r, line_len_nxt;
  logic        text_ended_r, text_ended_nxt;
  logic [2:0]  prefix_prog_r, prefix_prog_nxt;
  logic        prefix_seen_r, prefix_seen_nxt;
  prs_t        prs0_r, prs0_nxt, prs1_r, prs1_nxt;
  vals_t       cand0_r, cand0_nxt, cand1_r, cand1_nxt;
  vals_t       stored_r, stored_nxt;
  logic        valid_r, valid_nxt;

  // result register
  logic        out_valid_r;
  logic        out_kind_r;
  logic [7:0]  out_tx_r;
  logic [1:0]  out_status_r;
  logic        out_dvalid_r;
  vals_t       out_vals_r;
  logic        out_last_r;
  logic [1:0]  out_seq_r;
  logic [7:0]  addr_hold_r;

  logic        emit;
  logic        res_kind;
  logic [1:0]  res_status;
  logic        out_free;
  logic        advance;

  logic [31:0] elapsed_inc;
  logic [7:0]  len_inc;
  logic        w0, w1;
  vals_t       cand0_w, cand1_w;
  prs_t        prs0_c, prs1_c;
  logic [2:0]  n_sel;
  vals_t       cand_sel;
  logic        mark_hit;
  logic [2:0]  prog_inc;

  assign out_free  = !out_valid_r || (out_tready && out_last_r);
  assign advance   = in_valid_r && (!emit || out_free);
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    elapsed_inc = (elapsed_r == 32'hFFFF_FFFF) ? elapsed_r : elapsed_r + 32'd1;
    len_inc     = (line_len_r == 8'hFF) ? line_len_r : line_len_r + 8'd1;

    w0 = prs0_r.in_token && (prs0_r.count < NUM_FIELDS);
    w1 = prs1_r.in_token && (prs1_r.count < NUM_FIELDS);
    cand0_w = cand0_r;
    cand1_w = cand1_r;
    if (w0) cand0_w[prs0_r.count] = prs_value(prs0_r);
    if (w1) cand1_w[prs1_r.count] = prs_value(prs1_r);
    prs0_c = prs_close(prs0_r);
    prs1_c = prs_close(prs1_r);
    n_sel    = prefix_seen_r ? prs1_c.count : prs0_c.count;
    cand_sel = prefix_seen_r ? cand1_w : cand0_w;

    mark_hit = (prefix_prog_r < MARK_LEN) && (in_byte_r == mark_char(prefix_prog_r));
    prog_inc = mark_hit ? prefix_prog_r + 3'd1 :
               ((in_byte_r == CH_THREE) ? 3'd1 : 3'd0);

    waiting_nxt      = waiting_r;
    line_started_nxt = line_started_r;
    elapsed_nxt      = elapsed_r;
    line_len_nxt     = line_len_r;
    text_ended_nxt   = text_ended_r;
    prefix_prog_nxt  = prefix_prog_r;
    prefix_seen_nxt  = prefix_seen_r;
    prs0_nxt         = prs0_r;
    prs1_nxt         = prs1_r;
    cand0_nxt        = cand0_r;
    cand1_nxt        = cand1_r;
    stored_nxt       = stored_r;
    valid_nxt        = valid_r;
    emit             = 1'b0;
    res_kind         = KIND_REPORT;
    res_status       = ST_OK;

    case (in_cmd_r)
      CMD_POLL: begin
        waiting_nxt      = 1'b1;
        line_started_nxt = 1'b0;
        elapsed_nxt      = '0;
        line_len_nxt     = '0;
        text_ended_nxt   = 1'b0;
        prefix_prog_nxt  = '0;
        prefix_seen_nxt  = 1'b0;
        prs0_nxt         = '0;
        prs1_nxt         = '0;
        cand0_nxt        = '0;
        cand1_nxt        = '0;
        emit             = 1'b1;
        res_kind         = KIND_TX;
      end
      CMD_TICK: begin
        if (waiting_r) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= timeout_r) begin
            waiting_nxt = 1'b0;
            emit        = 1'b1;
            res_status  = ST_TIMEOUT;
          end
        end
      end
      CMD_BYTE: begin
        if (waiting_r && (elapsed_r < timeout_r)) begin
          if (!line_started_r) begin
            if (is_digit(in_byte_r)) begin
              line_started_nxt = 1'b1;
              line_len_nxt     = 8'd1;
            end
          end else begin
            line_len_nxt = len_inc;
          end
          if (line_started_r && ((in_byte_r == CH_CR) || (in_byte_r == CH_LF))) begin
            prs0_nxt  = prs0_c;
            prs1_nxt  = prs1_c;
            cand0_nxt = cand0_w;
            cand1_nxt = cand1_w;
            for (int i = 0; i < 6; i++) begin
              if (3'(i) < n_sel) stored_nxt[i] = cand_sel[i];
            end
            valid_nxt   = (n_sel == NUM_FIELDS);
            waiting_nxt = 1'b0;
            emit        = 1'b1;
            res_status  = valid_nxt ? ST_OK : ST_INCOMPLETE;
          end else if (line_started_r || is_digit(in_byte_r)) begin
            if (!text_ended_r) begin
              if (in_byte_r == CH_NUL) begin
                text_ended_nxt = 1'b1;
              end else begin
                prs0_nxt = prs_feed(prs0_r, in_byte_r);
                if (in_byte_r == CH_COMMA) cand0_nxt = cand0_w;
                if (prefix_seen_r) begin
                  prs1_nxt = prs_feed(prs1_r, in_byte_r);
                  if (in_byte_r == CH_COMMA) cand1_nxt = cand1_w;
                end else if (prog_inc >= MARK_LEN) begin
                  prefix_seen_nxt = 1'b1;
                  prefix_prog_nxt = '0;
                end else begin
                  prefix_prog_nxt = prog_inc;
                end
              end
            end
            if (line_started_r && (len_inc >= OVF_LEN)) begin
              waiting_nxt = 1'b0;
              emit        = 1'b1;
              res_status  = ST_OVERFLOW;
            end
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= 8'd48;
      timeout_r  <= 32'd1000;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DEV_ADDR: dev_addr_r <= cfg_wdata[7:0];
        REG_TIMEOUT:  timeout_r  <= cfg_wdata;
        default:      timeout_r  <= timeout_r;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_cmd_r  <= in_tuser;
      in_byte_r <= in_tdata;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r      <= 1'b0;
      line_started_r <= 1'b0;
      elapsed_r      <= '0;
      line_len_r     <= '0;
      text_ended_r   <= 1'b0;
      prefix_prog_r  <= '0;
      prefix_seen_r  <= 1'b0;
      prs0_r         <= '0;
      prs1_r         <= '0;
      cand0_r        <= '0;
      cand1_r        <= '0;
      stored_r       <= '0;
      valid_r        <= 1'b0;
    end else if (advance) begin
      waiting_r      <= waiting_nxt;
      line_started_r <= line_started_nxt;
      elapsed_r      <= elapsed_nxt;
      line_len_r     <= line_len_nxt;
      text_ended_r   <= text_ended_nxt;
      prefix_prog_r  <= prefix_prog_nxt;
      prefix_seen_r  <= prefix_seen_nxt;
      prs0_r         <= prs0_nxt;
      prs1_r         <= prs1_nxt;
      cand0_r        <= cand0_nxt;
      cand1_r        <= cand1_nxt;
      stored_r       <= stored_nxt;
      valid_r        <= valid_nxt;
    end
  end

  // result register; a poll walks through its three transmit bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      out_seq_r   <= '0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
      out_seq_r   <= '0;
      if (res_kind == KIND_TX) begin
        out_kind_r   <= KIND_TX;
        out_tx_r     <= CH_M;
        out_status_r <= ST_OK;
        out_dvalid_r <= 1'b0;
        out_vals_r   <= '0;
        out_last_r   <= 1'b0;
        addr_hold_r  <= dev_addr_r;
      end else begin
        out_kind_r   <= KIND_REPORT;
        out_tx_r     <= '0;
        out_status_r <= res_status;
        out_dvalid_r <= valid_nxt;
        out_vals_r   <= stored_nxt;
        out_last_r   <= 1'b1;
      end
    end else if (out_valid_r && out_tready) begin
      if (out_last_r) begin
        out_valid_r <= 1'b0;
      end else if (out_seq_r == 2'd0) begin
        out_tx_r  <= addr_hold_r;
        out_seq_r <= 2'd1;
      end else begin
        out_tx_r   <= CH_BANG;
        out_last_r <= 1'b1;
        out_seq_r  <= 2'd2;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'd0, out_vals_r[5], out_vals_r[4], out_vals_r[3], out_vals_r[2],
                       out_vals_r[1], out_vals_r[0], out_dvalid_r, out_status_r, out_tx_r};

  a_tx_run : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_TX) && !out_last_r && out_tready)
      |=> (out_valid_r && (out_kind_r == KIND_TX)))
    else $error("poll transmit run broken");

  a_report_ends_wait : assert property (@(posedge clk) disable iff (!rst_n)
    (advance && emit && (res_kind == KIND_REPORT)) |=> !waiting_r)
    else $error("report left the wait open");

  a_prefix_range : assert property (@(posedge clk) disable iff (!rst_n)
    prefix_prog_r < MARK_LEN)
    else $error("prefix progress out of range");

  a_ok_valid : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_REPORT) && (out_status_r == ST_OK)) |-> out_dvalid_r)
    else $error("ok report without valid data");

endmodule

`default_nettype wire

// ----- sim/sensor_poll_response_parser_unit_test.sv -----
// ----------------------------------------------------------------------------
// sensor_poll_response_parser_unit_test
// Self-checking bench for the poll/parse unit. Directed cases cover idle
// items, poll bytes, field extremes, the device tag, zero bytes, overflow and
// timeouts. Randomized poll/response sequences with stalls on both sides
// follow. Every result item is checked against an in-bench predictor.
// ----------------------------------------------------------------------------
module sensor_poll_response_parser_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import spr_pkg::*;

  localparam int LINE_CAP    = 64;
  localparam int STALL_LIMIT = 4000;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  // device tag, first character in the low byte
  localparam logic [47:0] TAG_TEXT = {CH_BANG, CH_ZERO, CH_ZERO, 8'h34, 8'h32, CH_THREE};

  typedef struct packed {
    logic       kind;
    logic [7:0] tx;
    logic [1:0] status;
    logic       flag;
    vals_t      vals;
    logic       fin;
  } result_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready = 1'b1;
  logic [111:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;
  logic         cfg_wr_en;
  logic         cfg_index;
  logic [31:0]  cfg_wdata;

  sensor_poll_response_parser_unit #(.LINE_CAPACITY(LINE_CAP)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // predictor state
  logic [7:0]  dev_addr    = 8'd48;
  logic [31:0] tick_limit  = 32'd1000;
  logic        wait_open   = 1'b0;
  logic        line_open   = 1'b0;
  logic [31:0] tick_count  = '0;
  int          line_len    = 0;
  logic        text_done   = 1'b0;
  int          tag_pos     = 0;
  logic        tag_found   = 1'b0;
  prs_t        fparse [2]  = '{'0, '0};
  vals_t       field_cand [2] = '{'0, '0};
  vals_t       field_keep  = '0;
  logic        keep_ok     = 1'b0;

  result_t     pending_results [$];
  logic [7:0]  line_q [$];
  int          mismatches = 0;
  int          items_accepted = 0;
  int          results_seen = 0;
  int          idle_cycles = 0;
  int          ready_hold = 0;
  logic        calm = 1'b0;

  task automatic push_result(logic kind, logic [7:0] tx, logic [1:0] st, logic fin);
    result_t r;
    r.kind   = kind;
    r.tx     = tx;
    r.status = st;
    r.flag   = (kind == KIND_REPORT) ? keep_ok : 1'b0;
    r.vals   = (kind == KIND_REPORT) ? field_keep : '0;
    r.fin    = fin;
    pending_results.push_back(r);
  endtask

  task automatic field_close(int k);
    if (fparse[k].in_token) begin
      if (fparse[k].count < NUM_FIELDS) begin
        field_cand[k][fparse[k].count] = fparse[k].negative ? 16'd0 - fparse[k].acc
                                                            : fparse[k].acc;
        fparse[k].count = fparse[k].count + 3'd1;
      end
      fparse[k].in_token = 1'b0;
    end
  endtask

  task automatic field_feed(int k, logic [7:0] c);
    if (c == CH_COMMA) begin
      field_close(k);
      return;
    end
    if (!fparse[k].in_token) begin
      fparse[k].in_token = 1'b1;
      fparse[k].phase    = PH_SPACE;
      fparse[k].negative = 1'b0;
      fparse[k].acc      = '0;
    end
    if (fparse[k].phase == PH_SPACE) begin
      if (c == CH_SPACE || c inside {[8'd9:8'd13]}) begin
      end else if (c == CH_PLUS || c == CH_MINUS) begin
        fparse[k].negative = (c == CH_MINUS);
        fparse[k].phase    = PH_DIGITS;
      end else if (c inside {[CH_ZERO:CH_NINE]}) begin
        fparse[k].acc   = 16'(c - CH_ZERO);
        fparse[k].phase = PH_DIGITS;
      end else begin
        fparse[k].phase = PH_DONE;
      end
    end else if (fparse[k].phase == PH_DIGITS) begin
      if (c inside {[CH_ZERO:CH_NINE]})
        fparse[k].acc = fparse[k].acc * 16'd10 + 16'(c - CH_ZERO);
      else fparse[k].phase = PH_DONE;
    end
  endtask

  task automatic text_feed(logic [7:0] c);
    if (text_done) return;
    if (c == CH_NUL) begin
      text_done = 1'b1;
      return;
    end
    field_feed(0, c);
    if (tag_found) begin
      field_feed(1, c);
    end else begin
      if (tag_pos < 6 && c == TAG_TEXT[8*tag_pos +: 8]) tag_pos++;
      else tag_pos = (c == CH_THREE) ? 1 : 0;
      if (tag_pos >= 6) begin
        tag_found = 1'b1;
        tag_pos   = 0;
      end
    end
  endtask

  task automatic compute_parser_results(logic [1:0] cmd, logic [7:0] c);
    int sel;
    int n;
    case (cmd)
      CMD_POLL: begin
        wait_open     = 1'b1;
        line_open     = 1'b0;
        tick_count    = '0;
        line_len      = 0;
        text_done     = 1'b0;
        tag_pos       = 0;
        tag_found     = 1'b0;
        fparse[0]     = '0;
        fparse[1]     = '0;
        field_cand[0] = '0;
        field_cand[1] = '0;
        push_result(KIND_TX, CH_M, ST_OK, 1'b0);
        push_result(KIND_TX, dev_addr, ST_OK, 1'b0);
        push_result(KIND_TX, CH_BANG, ST_OK, 1'b1);
      end
      CMD_TICK: begin
        if (wait_open) begin
          if (tick_count != '1) tick_count++;
          if (tick_count >= tick_limit) begin
            wait_open = 1'b0;
            push_result(KIND_REPORT, 8'd0, ST_TIMEOUT, 1'b1);
          end
        end
      end
      CMD_BYTE: begin
        if (wait_open && tick_count < tick_limit) begin
          if (!line_open) begin
            if (c inside {[CH_ZERO:CH_NINE]}) begin
              line_open = 1'b1;
              line_len  = 1;
              text_feed(c);
            end
          end else begin
            if (line_len < 255) line_len++;
            if (c == CH_CR || c == CH_LF) begin
              sel = tag_found ? 1 : 0;
              field_close(0);
              field_close(1);
              n = int'(fparse[sel].count);
              for (int i = 0; i < n; i++) field_keep[i] = field_cand[sel][i];
              keep_ok   = (n == NUM_FIELDS);
              wait_open = 1'b0;
              push_result(KIND_REPORT, 8'd0, keep_ok ? ST_OK : ST_INCOMPLETE, 1'b1);
            end else begin
              text_feed(c);
              if (line_len >= LINE_CAP - 1) begin
                wait_open = 1'b0;
                push_result(KIND_REPORT, 8'd0, ST_OVERFLOW, 1'b1);
              end
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // result checking
  function automatic string value_name(int i);
    case (i)
      0:       return "wind_speed";
      1:       return "wind_direction";
      2:       return "input_one";
      3:       return "input_two";
      4:       return "input_three";
      default: return "input_four";
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0h, actual %0h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result item with none expected: kind %0d tx_byte %0h", out_tuser, out_tdata[7:0]);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_tuser));
        check_field("tx_byte", 32'(want.tx), 32'(out_tdata[7:0]));
        check_field("status", 32'(want.status), 32'(out_tdata[9:8]));
        check_field("data_valid", 32'(want.flag), 32'(out_tdata[10]));
        for (int i = 0; i < 6; i++)
          check_field(value_name(i), 32'(want.vals[i]), 32'(out_tdata[11 + 16*i +: 16]));
        check_field("last", 32'(want.fin), 32'(out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  always @(negedge clk) begin
    int n;
    if (calm || !rst_n) begin
      out_tready <= 1'b1;
    end else if (ready_hold > 0) begin
      out_tready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      n = pick_gap();
      if (n > 0) begin
        out_tready <= 1'b0;
        ready_hold <= n - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // stimulus primitives
  task automatic send_item(logic [1:0] cmd, logic [7:0] b);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    items_accepted++;
    compute_parser_results(cmd, b);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(CMD_BYTE, s[i]);
  endtask

  task automatic send_tag();
    for (int i = 0; i < 6; i++) send_item(CMD_BYTE, TAG_TEXT[8*i +: 8]);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_DEV_ADDR) dev_addr = v[7:0];
    else tick_limit = v;
  endtask

  // random line construction
  function automatic logic [7:0] junk_byte();
    case ($urandom_range(0, 5))
      0:       return 8'(8'h61 + $urandom_range(0, 25));
      1:       return CH_CR;
      2:       return CH_LF;
      3:       return CH_COMMA;
      4:       return 8'(8'h80 + $urandom_range(0, 127));
      default: return CH_NUL;
    endcase
  endfunction

  function automatic logic [7:0] any_digit();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  task automatic push_tag();
    for (int i = 0; i < 6; i++) line_q.push_back(TAG_TEXT[8*i +: 8]);
  endtask

  task automatic push_token();
    int len;
    if ($urandom_range(0, 9) == 0) return;
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0:       line_q.push_back(CH_SPACE);
        1:       line_q.push_back(CH_TAB);
        2:       line_q.push_back(CH_VT);
        default: line_q.push_back(CH_FF);
      endcase
    end
    case ($urandom_range(0, 9))
      0:       line_q.push_back(CH_PLUS);
      1:       line_q.push_back(CH_MINUS);
      default: ;
    endcase
    len = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
    repeat (len) line_q.push_back(any_digit());
    if ($urandom_range(0, 9) == 0) begin
      line_q.push_back(8'h67);
      line_q.push_back(any_digit());
    end
  endtask

  task automatic build_line();
    int tag_mode;
    int n_fields;
    line_q.delete();
    repeat ($urandom_range(0, 2)) line_q.push_back(junk_byte());
    tag_mode = $urandom_range(0, 9);
    if (tag_mode >= 4 && tag_mode <= 6) begin
      push_tag();
    end else begin
      line_q.push_back(any_digit());
      if (tag_mode == 7) begin
        line_q.push_back(CH_THREE);
        push_tag();
      end else if (tag_mode == 8) begin
        push_tag();
        line_q[line_q.size() - 1 - $urandom_range(0, 5)] = any_digit();
        line_q.push_back(CH_COMMA);
      end
    end
    n_fields = $urandom_range(3, 8);
    for (int i = 0; i < n_fields; i++) begin
      push_token();
      if (i != n_fields - 1 || $urandom_range(0, 3) == 0) line_q.push_back(CH_COMMA);
    end
    if ($urandom_range(0, 9) == 0) line_q.insert($urandom_range(1, line_q.size() - 1), CH_NUL);
    line_q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
  endtask

  task automatic build_overflow();
    line_q.delete();
    line_q.push_back(any_digit());
    repeat (64) begin
      case ($urandom_range(0, 5))
        0:       line_q.push_back(CH_COMMA);
        1:       line_q.push_back(8'($urandom_range(14, 255)));
        default: line_q.push_back(any_digit());
      endcase
    end
    line_q.push_back(CH_CR);
  endtask

  // bytes of the line, with an occasional tick in between
  task automatic send_line(int upto);
    for (int i = 0; i < line_q.size() && i < upto; i++) begin
      if ($urandom_range(0, 11) == 0) send_item(CMD_TICK, 8'($urandom_range(0, 255)));
      send_item(CMD_BYTE, line_q[i]);
    end
  endtask

  task automatic run_random_sequence();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      send_item(CMD_POLL, 8'($urandom_range(0, 255)));
      build_line();
      send_line(line_q.size());
    end else if (pick < 65) begin
      send_item(CMD_POLL, 8'($urandom_range(0, 255)));
      build_overflow();
      send_line(line_q.size());
    end else if (pick < 75) begin
      send_item(CMD_POLL, 8'($urandom_range(0, 255)));
      build_line();
      send_line($urandom_range(0, 4));
      n = 0;
      while (wait_open && n < 40) begin
        send_item(CMD_TICK, 8'($urandom_range(0, 255)));
        n++;
      end
    end else if (pick < 87) begin
      send_item(CMD_POLL, 8'($urandom_range(0, 255)));
      build_line();
      send_line($urandom_range(1, line_q.size() - 1));
      send_item(CMD_POLL, 8'($urandom_range(0, 255)));
      build_line();
      send_line(line_q.size());
    end else begin
      repeat ($urandom_range(2, 5))
        send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end
  endtask

  // tests
  task automatic test_idle_items();
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_BYTE, CH_NUL);
    send_item(CMD_TICK, 8'h5A);
    send_item(CMD_SPARE, 8'hA5);
    send_item(CMD_BYTE, CH_ZERO + 8'd5);
    send_item(CMD_POLL, 8'h00);
    send_text("1,2,3,4,5,6\r");
  endtask

  task automatic test_poll_address();
    wait_for_drain();
    write_reg(REG_DEV_ADDR, 32'hFFFF_FF00);
    send_item(CMD_POLL, 8'hFF);
    wait_for_drain();
    write_reg(REG_DEV_ADDR, 32'h0000_00FF);
    send_item(CMD_POLL, 8'h00);
  endtask

  task automatic test_field_extremes();
    calm = 1'b1;
    send_item(CMD_POLL, 8'h3C);
    send_text("x\r65535,-1,+7,\t9,,70000,0,8\n");
    send_item(CMD_POLL, 8'hC3);
    send_text("12, -3 ,ab,-\r");
    calm = 1'b0;
  endtask

  task automatic test_device_tag();
    send_item(CMD_POLL, 8'h01);
    send_text("0");
    send_tag();
    send_text("5,6,7,8,9,10\r");
    send_item(CMD_POLL, 8'h02);
    send_text("3");
    send_tag();
    send_text("1,2\n");
  endtask

  task automatic test_zero_byte();
    send_item(CMD_POLL, 8'h04);
    send_text("1,2,");
    send_item(CMD_BYTE, CH_NUL);
    send_text("3,4,5,6\r");
  endtask

  task automatic test_overflow();
    send_item(CMD_POLL, 8'h08);
    for (int i = 0; i < 65; i++)
      send_item(CMD_BYTE, (i % 4 == 3) ? CH_COMMA : CH_ZERO + 8'(i % 10));
    send_text("\n");
  endtask

  task automatic test_timeouts();
    wait_for_drain();
    write_reg(REG_TIMEOUT, 32'd0);
    send_item(CMD_POLL, 8'h10);
    send_item(CMD_BYTE, CH_ZERO + 8'd1);
    send_item(CMD_TICK, 8'h00);
    wait_for_drain();
    write_reg(REG_TIMEOUT, 32'd2);
    send_item(CMD_POLL, 8'h20);
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_BYTE, CH_ZERO + 8'd4);
    send_item(CMD_TICK, 8'hFF);
    wait_for_drain();
    write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
    send_item(CMD_POLL, 8'h40);
    send_text("9,");
    repeat (3) send_item(CMD_TICK, 8'h00);
    // lowered limit while the wait is still open
    wait_for_drain();
    write_reg(REG_TIMEOUT, 32'd1);
    send_item(CMD_BYTE, CH_ZERO + 8'd7);
    send_item(CMD_BYTE, CH_CR);
    send_item(CMD_TICK, 8'h80);
  endtask

  task automatic test_random_traffic();
    int item_base;
    int next_phase_at;
    int phase;
    item_base     = items_accepted;
    next_phase_at = 0;
    phase         = 0;
    while ((items_accepted - item_base) < 80) begin
      if (items_accepted - item_base >= next_phase_at) begin
        wait_for_drain();
        calm = (phase % 4 == 3);
        case (phase % 4)
          0: begin
            write_reg(REG_DEV_ADDR, $urandom_range(0, 255));
            write_reg(REG_TIMEOUT, $urandom_range(8, 40));
          end
          1: begin
            write_reg(REG_DEV_ADDR, 32'hFF);
            write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
          end
          2: begin
            write_reg(REG_DEV_ADDR, 32'h00);
            write_reg(REG_TIMEOUT, $urandom_range(1, 6));
          end
          default: begin
            write_reg(REG_DEV_ADDR, $urandom);
            write_reg(REG_TIMEOUT, 32'd1000);
          end
        endcase
        phase++;
        next_phase_at += 20;
      end
      run_random_sequence();
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tuser  = CMD_TICK;
    cfg_wr_en = 1'b0;
    cfg_index = REG_DEV_ADDR;
    cfg_wdata = 32'd0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_items();
    test_poll_address();
    test_field_extremes();
    test_device_tag();
    test_zero_byte();
    test_overflow();
    test_timeouts();
    test_random_traffic();

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d input items and %0d result items: polls, parsed lines,",
             items_accepted, results_seen);
    $display("tagged lines, zero bytes, overflow, timeouts and idle commands.");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sensor_poll_response_parser_unit.f -----
src/spr_pkg.sv
src/sensor_poll_response_parser_unit.sv
sim/sensor_poll_response_parser_unit_test.sv
